// ----- design/bspu_pkg.sv -----
package bspu_pkg;

	// sizing
	localparam int BUF_BYTES  = 512;
	localparam int MARK_DEPTH = 8;
	localparam int MAX_BITS   = 64;

	// field widths
	localparam int CMD_W   = 4;
	localparam int DATA_W  = 64;
	localparam int CNT_W   = 7;
	localparam int OFS_W   = 13;
	localparam int IDX_W   = OFS_W - 3;
	localparam int SIZE_W  = 10;
	localparam int MARKS_W = 4;
	localparam int CFG_W   = 10;

	// derived storage sizes
	localparam int BUF_DEPTH = (BUF_BYTES > (1 << IDX_W)) ? (1 << IDX_W) : BUF_BYTES;
	localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int MARK_AW   = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
	localparam int MCNT_W    = $clog2(MARK_DEPTH + 1);
	localparam int BUF_CLAMP = (BUF_BYTES > 1023) ? 1023 : BUF_BYTES;

	localparam logic [OFS_W-1:0]  BUF_BITS  = OFS_W'(BUF_CLAMP * 8);
	localparam logic [OFS_W-1:0]  OFS_MAX   = '1;
	localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_BITS);
	localparam logic [SIZE_W-1:0] SIZE_MAX  = '1;
	localparam logic [CFG_W-1:0]  CFG_BYTES_RST = CFG_W'(512);

	// configuration register indexes
	localparam logic REG_BUFFER_BYTES  = 1'b0;
	localparam logic REG_WRITE_ENABLED = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH          = 4'd0,
		CMD_GET           = 4'd1,
		CMD_GET_AT        = 4'd2,
		CMD_DROP          = 4'd3,
		CMD_DROP_TO       = 4'd4,
		CMD_MARK          = 4'd5,
		CMD_DROP_RECALL   = 4'd6,
		CMD_POS_RECALL    = 4'd7,
		CMD_IGNORE_RECALL = 4'd8,
		CMD_SEEK          = 4'd9,
		CMD_FINALIZE      = 4'd10,
		CMD_DEFINALIZE    = 4'd11,
		CMD_CLEAR         = 4'd12
	} cmd_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_GET,
		S_DROP,
		S_FIN,
		S_MARK_RD,
		S_FILL,
		S_DONE
	} state_e;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] data_value;
		logic [CNT_W-1:0]  bit_count;
		logic [OFS_W-1:0]  position;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_value;
		logic [OFS_W-1:0]   bit_offset;
		logic [SIZE_W-1:0]  size_bytes;
		logic               error_flag;
		logic [MARKS_W-1:0] marks_held;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] buffer_bytes;
		logic             write_enabled;
	} cfg_t;

	typedef struct packed {
		logic              re;
		logic [BUF_AW-1:0] raddr;
		logic              we;
		logic [BUF_AW-1:0] waddr;
		logic [7:0]        wdata;
	} buf_req_t;

	typedef struct packed {
		logic               re;
		logic [MARK_AW-1:0] raddr;
		logic               we;
		logic [MARK_AW-1:0] waddr;
		logic [OFS_W-1:0]   wdata;
	} mark_req_t;

endpackage

// ----- design/bspu_ram.sv -----
module bspu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/bspu_seq.sv -----
module bspu_seq
	import bspu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  cfg_t                cfg,
	output buf_req_t            buf_req,
	input  logic [7:0]          buf_rdata,
	output mark_req_t           mark_req,
	input  logic [OFS_W-1:0]    mark_rdata
);

	state_e state_q, state_d;
	state_e ret_q, ret_d;

	logic [CMD_W-1:0]  cmd_q, cmd_d;
	logic [DATA_W-1:0] data_q, data_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  done_q, done_d;
	logic [OFS_W-1:0]  tgt_q, tgt_d;
	logic [DATA_W-1:0] rv_q, rv_d;

	logic [OFS_W-1:0]  offset_q, offset_d;
	logic [MCNT_W-1:0] mark_cnt_q, mark_cnt_d;
	logic              err_q, err_d;

	// working byte: one buffer entry held in flops
	logic [7:0]        cb_q, cb_d;
	logic [IDX_W-1:0]  cidx_q, cidx_d;
	logic              cvalid_q, cvalid_d;
	logic              cdirty_q, cdirty_d;
	logic [IDX_W-1:0]  fill_idx_q, fill_idx_d;

	logic              out_valid_q, out_valid_d;
	out_item_t         out_q, out_d;

	logic              accept;
	logic [CNT_W-1:0]  cnt_in;
	logic [OFS_W-1:0]  cnt_ext;
	logic [CFG_W-1:0]  lim_bytes;
	logic [OFS_W-1:0]  lim_bits;
	logic              below_lim;
	logic [OFS_W-1:0]  ofs_m1;
	logic [IDX_W-1:0]  idx_cur, idx_drop, idx_need;
	logic              hit, need_mem, miss;
	logic              bits_done, drop_done, drop_beyond, fin_ok;
	logic [CNT_W-1:0]  chunk_left;
	logic [3:0]        chunk_n;
	logic [2:0]        bit_sel;
	logic              push_bit;
	logic              get_bit;
	logic [OFS_W-1:0]  ofs_inc;
	logic [2:0]        fin_sh;
	logic [OFS_W:0]    sz_sum;
	logic [OFS_W-3:0]  sz_div;
	logic [SIZE_W-1:0] size_now;
	logic              out_load;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// count clamp and limit
	assign cnt_in    = (in_data.bit_count > MAX_CNT) ? MAX_CNT : in_data.bit_count;
	assign cnt_ext   = OFS_W'(cnt_in);
	assign lim_bytes = (cfg.buffer_bytes > CFG_W'(BUF_CLAMP)) ? CFG_W'(BUF_CLAMP)
		: cfg.buffer_bytes;
	assign lim_bits  = {lim_bytes, 3'b000};
	assign below_lim = (offset_q < lim_bits);

	// byte addressing and working byte lookup
	assign ofs_m1      = offset_q - OFS_W'(1);
	assign idx_cur     = offset_q[OFS_W-1:3];
	assign idx_drop    = ofs_m1[OFS_W-1:3];
	assign idx_need    = (state_q == S_DROP) ? idx_drop : idx_cur;
	assign hit         = cvalid_q && (cidx_q == idx_need);
	assign bits_done   = (done_q == cnt_q);
	assign drop_done   = (offset_q <= tgt_q);
	assign drop_beyond = ({1'b0, idx_drop} >= (IDX_W + 1)'(BUF_DEPTH));
	assign fin_ok      = (offset_q[2:0] != 3'b000)
		&& ({1'b0, idx_cur} < (IDX_W + 1)'(BUF_DEPTH));

	always_comb begin
		need_mem = 1'b0;
		unique case (state_q)
			S_PUSH: need_mem = !bits_done && below_lim;
			S_GET:  need_mem = !bits_done && below_lim;
			S_DROP: need_mem = !drop_done && !drop_beyond;
			S_FIN:  need_mem = 1'b1;
			default: need_mem = 1'b0;
		endcase
	end
	assign miss = need_mem && !hit;

	// push bit: low bits of each data byte, msb of those first
	assign chunk_left = cnt_q - {1'b0, done_q[5:3], 3'b000};
	assign chunk_n    = (chunk_left >= CNT_W'(8)) ? 4'd8 : chunk_left[3:0];
	assign bit_sel    = 3'(chunk_n - 4'd1 - {1'b0, done_q[2:0]});
	assign push_bit   = data_q[{done_q[5:3], bit_sel}];

	// get bit, offset saturates at the top
	assign get_bit = below_lim ? cb_q[~offset_q[2:0]] : 1'b0;
	assign ofs_inc = (offset_q == OFS_MAX) ? offset_q : offset_q + OFS_W'(1);

	// finalize shift amount
	assign fin_sh = 3'(4'd8 - {1'b0, offset_q[2:0]});

	// bytes touched, saturating
	assign sz_sum   = {1'b0, offset_q} + (OFS_W + 1)'(7);
	assign sz_div   = sz_sum[OFS_W:3];
	assign size_now = (|sz_div[OFS_W-3:SIZE_W]) ? SIZE_MAX : sz_div[SIZE_W-1:0];

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_data.cmd)
						CMD_PUSH: state_d = cfg.write_enabled ? S_PUSH : S_DONE;
						CMD_GET, CMD_GET_AT: state_d = S_GET;
						CMD_DROP, CMD_DROP_TO: state_d = cfg.write_enabled ? S_DROP : S_DONE;
						CMD_DROP_RECALL, CMD_POS_RECALL, CMD_IGNORE_RECALL:
							state_d = (mark_cnt_q == '0) ? S_DONE : S_MARK_RD;
						CMD_FINALIZE, CMD_DEFINALIZE:
							state_d = (cfg.write_enabled && fin_ok) ? S_FIN : S_DONE;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_PUSH: begin
				priority if (bits_done || !below_lim) begin
					state_d = S_DONE;
				end else if (miss) begin
					state_d = S_FILL;
					ret_d   = S_PUSH;
				end
			end
			S_GET: begin
				priority if (bits_done) begin
					state_d = S_DONE;
				end else if (miss) begin
					state_d = S_FILL;
					ret_d   = S_GET;
				end
			end
			S_DROP: begin
				priority if (drop_done) begin
					state_d = S_DONE;
				end else if (miss) begin
					state_d = S_FILL;
					ret_d   = S_DROP;
				end
			end
			S_FIN: begin
				if (miss) begin
					state_d = S_FILL;
					ret_d   = S_FIN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_MARK_RD: begin
				state_d = ((cmd_q == CMD_DROP_RECALL) && cfg.write_enabled) ? S_DROP : S_DONE;
			end
			S_FILL: state_d = ret_q;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath and memory requests
	always_comb begin
		cmd_d       = cmd_q;
		data_d      = data_q;
		cnt_d       = cnt_q;
		done_d      = done_q;
		tgt_d       = tgt_q;
		rv_d        = rv_q;
		offset_d    = offset_q;
		mark_cnt_d  = mark_cnt_q;
		err_d       = err_q;
		cb_d        = cb_q;
		cidx_d      = cidx_q;
		cvalid_d    = cvalid_q;
		cdirty_d    = cdirty_q;
		fill_idx_d  = fill_idx_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && out_stall;
		buf_req     = '0;
		mark_req    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_d  = in_data.cmd;
					data_d = in_data.data_value;
					cnt_d  = cnt_in;
					done_d = '0;
					rv_d   = '0;
					unique case (in_data.cmd)
						CMD_PUSH: begin
							if (!cfg.write_enabled) begin
								err_d = 1'b1;
							end
						end
						CMD_GET_AT, CMD_SEEK: offset_d = in_data.position;
						CMD_DROP: begin
							if (!cfg.write_enabled) begin
								err_d = 1'b1;
							end else begin
								tgt_d = (cnt_ext > offset_q) ? '0 : offset_q - cnt_ext;
							end
						end
						CMD_DROP_TO: begin
							if (!cfg.write_enabled) begin
								err_d = 1'b1;
							end else begin
								tgt_d = in_data.position;
							end
						end
						CMD_MARK: begin
							if (mark_cnt_q >= MCNT_W'(MARK_DEPTH)) begin
								err_d = 1'b1;
							end else begin
								mark_req.we    = 1'b1;
								mark_req.waddr = mark_cnt_q[MARK_AW-1:0];
								mark_req.wdata = offset_q;
								mark_cnt_d     = mark_cnt_q + MCNT_W'(1);
							end
						end
						CMD_DROP_RECALL, CMD_POS_RECALL, CMD_IGNORE_RECALL: begin
							if (mark_cnt_q == '0) begin
								err_d = 1'b1;
							end else begin
								mark_cnt_d     = mark_cnt_q - MCNT_W'(1);
								mark_req.re    = 1'b1;
								mark_req.raddr = mark_cnt_d[MARK_AW-1:0];
							end
						end
						CMD_FINALIZE: begin
							if (!cfg.write_enabled) begin
								err_d = 1'b1;
							end
						end
						CMD_CLEAR: begin
							offset_d = '0;
							err_d    = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			S_MARK_RD: begin
				// popped mark arrives from the stack memory
				if (cmd_q == CMD_DROP_RECALL) begin
					if (cfg.write_enabled) begin
						tgt_d = mark_rdata;
					end else begin
						err_d = 1'b1;
					end
				end else if (cmd_q == CMD_POS_RECALL) begin
					offset_d = mark_rdata;
				end
			end
			S_PUSH: begin
				if (!bits_done) begin
					if (!below_lim) begin
						err_d = 1'b1;
					end else if (hit) begin
						cb_d     = {cb_q[6:0], push_bit};
						cdirty_d = 1'b1;
						offset_d = offset_q + OFS_W'(1);
						done_d   = done_q + CNT_W'(1);
					end
				end
			end
			S_GET: begin
				if (!bits_done && (hit || !below_lim)) begin
					if (!below_lim) begin
						err_d = 1'b1;
					end
					for (int b = 0; b < 8; b++) begin
						if (done_q[5:3] == 3'(b)) begin
							rv_d[b*8 +: 8] = {rv_q[b*8 +: 7], get_bit};
						end
					end
					offset_d = ofs_inc;
					done_d   = done_q + CNT_W'(1);
				end
			end
			S_DROP: begin
				if (!drop_done) begin
					if (drop_beyond) begin
						// bits past the buffer go back in one step
						offset_d = (tgt_q > BUF_BITS) ? tgt_q : BUF_BITS;
					end else if (hit) begin
						cb_d     = {1'b0, cb_q[7:1]};
						cdirty_d = 1'b1;
						offset_d = ofs_m1;
					end
				end
			end
			S_FIN: begin
				if (hit) begin
					cb_d     = (cmd_q == CMD_FINALIZE) ? (cb_q << fin_sh) : (cb_q >> fin_sh);
					cdirty_d = 1'b1;
				end
			end
			S_FILL: begin
				cb_d     = buf_rdata;
				cidx_d   = fill_idx_q;
				cvalid_d = 1'b1;
				cdirty_d = 1'b0;
			end
			S_DONE: begin
				if (out_load) begin
					out_valid_d      = 1'b1;
					out_d.read_value = rv_q;
					out_d.bit_offset = offset_q;
					out_d.size_bytes = size_now;
					out_d.error_flag = err_q;
					out_d.marks_held = MARKS_W'(mark_cnt_q);
				end
			end
			default: begin
			end
		endcase

		// miss: write back the working byte and fetch the needed one
		if (miss) begin
			buf_req.re    = 1'b1;
			buf_req.raddr = idx_need[BUF_AW-1:0];
			fill_idx_d    = idx_need;
			cvalid_d      = 1'b0;
			cdirty_d      = 1'b0;
			if (cvalid_q && cdirty_q) begin
				buf_req.we    = 1'b1;
				buf_req.waddr = cidx_q[BUF_AW-1:0];
				buf_req.wdata = cb_q;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			offset_q    <= '0;
			mark_cnt_q  <= '0;
			err_q       <= 1'b0;
			cvalid_q    <= 1'b0;
			cdirty_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			offset_q    <= offset_d;
			mark_cnt_q  <= mark_cnt_d;
			err_q       <= err_d;
			cvalid_q    <= cvalid_d;
			cdirty_q    <= cdirty_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		data_q     <= data_d;
		cnt_q      <= cnt_d;
		done_q     <= done_d;
		tgt_q      <= tgt_d;
		rv_q       <= rv_d;
		cb_q       <= cb_d;
		cidx_q     <= cidx_d;
		fill_idx_q <= fill_idx_d;
		out_q      <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// a modified working byte always belongs to a loaded entry
	a_dirty_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cdirty_q |-> cvalid_q)
		else $error("working byte dirty without a loaded entry");

	// write-back and fetch never hit the same buffer entry
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_req.we && buf_req.re) |-> (buf_req.waddr != buf_req.raddr))
		else $error("buffer read and write to the same entry");

	// mark stack never holds more than its depth
	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mark_cnt_q <= MCNT_W'(MARK_DEPTH))
		else $error("mark count past stack depth");

	// a finished result waits while the output register is held
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> (state_q == S_DONE && out_valid_q))
		else $error("result overwrote a held output");

	// a fetch is always followed by the fill cycle
	a_fill_after_miss: assert property (@(posedge clk) disable iff (!arst_n)
		buf_req.re |=> (state_q == S_FILL))
		else $error("buffer fetch without fill");
`endif

endmodule

// ----- design/bit_stream_packer_unpacker.sv -----
// channel   handshake              payload
// -------   ---------------------  -------------------------------------------------
// in        in_valid / in_stall    in_data: cmd, data_value, bit_count, position
// out       out_valid / out_stall  out_data: read_value, bit_offset, size_bytes,
//                                  error_flag, marks_held
// cfg       cfg_wr_en              cfg_index, cfg_data (no wait, no read-back)
//
// One request at a time. Simple commands go from accept to the done state and then to the output register.
// Push and get move one bit at a time, plus a fill state each time a new buffer
// byte is fetched; drops move one bit at a time plus the same fill state per
// fetch, set by the single working byte in front of the buffer memory.
// Recalls add a state for the mark stack read. No clearing pass after reset.
// The next request is taken while a result waits in the output register.
module bit_stream_packer_unpacker
	import bspu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  logic                cfg_wr_en,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	cfg_t             cfg_q;
	buf_req_t         buf_req;
	mark_req_t        mark_req;
	logic [7:0]       buf_rdata;
	logic [OFS_W-1:0] mark_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_bytes  <= CFG_BYTES_RST;
			cfg_q.write_enabled <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BUFFER_BYTES:  cfg_q.buffer_bytes  <= cfg_data;
				REG_WRITE_ENABLED: cfg_q.write_enabled <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// byte buffer
	bspu_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_buf_ram (
		.clk   (clk),
		.we    (buf_req.we),
		.waddr (buf_req.waddr),
		.wdata (buf_req.wdata),
		.re    (buf_req.re),
		.raddr (buf_req.raddr),
		.rdata (buf_rdata)
	);

	// mark stack
	bspu_ram #(
		.WIDTH (OFS_W),
		.DEPTH (MARK_DEPTH)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_req.we),
		.waddr (mark_req.waddr),
		.wdata (mark_req.wdata),
		.re    (mark_req.re),
		.raddr (mark_req.raddr),
		.rdata (mark_rdata)
	);

	// command sequencer
	bspu_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg        (cfg_q),
		.buf_req    (buf_req),
		.buf_rdata  (buf_rdata),
		.mark_req   (mark_req),
		.mark_rdata (mark_rdata)
	);

endmodule

// ----- dv/bit_stream_packer_unpacker_test.sv -----
`timescale 1ns / 100ps

module bit_stream_packer_unpacker_test;
	import bspu_pkg::*;

	localparam int unsigned OFS_TOP = 8191;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_data;
	logic             cfg_wr_en;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// shadow of the buffer, offset, mark stack and registers
	logic [7:0]  buf_img [BUF_BYTES];
	int unsigned cur_ofs = 0;
	int unsigned mark_img [MARK_DEPTH];
	int unsigned mark_cnt = 0;
	bit          err_img = 1'b0;
	int unsigned cfg_bytes = 512;
	bit          cfg_wen = 1'b1;

	out_item_t   pending_results [$];
	int          fail_count = 0;
	int          sent_count = 0;
	bit          in_gaps_on = 1'b1;
	bit          out_gaps_on = 1'b1;

	bit_stream_packer_unpacker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#200_000_000;
		$display("Verification failed");
		$finish;
	end

	// bit limit from the length register, clamped to the buffer
	function automatic int unsigned bit_limit();
		int unsigned b;
		b = cfg_bytes;
		if (b > BUF_BYTES)
			b = BUF_BYTES;
		return b * 8;
	endfunction

	// one bit into the current byte, skipped at the limit
	function automatic void shift_in_bit(input bit b);
		int unsigned idx;
		if (cur_ofs >= bit_limit()) begin
			err_img = 1'b1;
			return;
		end
		idx = cur_ofs / 8;
		buf_img[idx] = {buf_img[idx][6:0], b};
		cur_ofs++;
	endfunction

	// one bit back out, no byte change beyond the buffer
	function automatic void shift_out_bit();
		int unsigned idx;
		if (cur_ofs == 0)
			return;
		cur_ofs--;
		idx = cur_ofs / 8;
		if (idx < BUF_BYTES)
			buf_img[idx] = buf_img[idx] >> 1;
	endfunction

	// read one bit msb first, zero and error past the limit
	function automatic bit fetch_bit();
		bit b;
		b = 1'b0;
		if (cur_ofs < bit_limit())
			b = buf_img[cur_ofs / 8][7 - cur_ofs % 8];
		else
			err_img = 1'b1;
		if (cur_ofs < OFS_TOP)
			cur_ofs++;
		return b;
	endfunction

	function automatic logic [DATA_W-1:0] fetch_bits(input int unsigned n);
		logic [DATA_W-1:0] v;
		logic [7:0]        b;
		int unsigned       sh;
		v = '0;
		for (int unsigned i = 0; i < n; i++) begin
			sh = (i / 8) * 8;
			b = v[sh +: 8];
			b = {b[6:0], fetch_bit()};
			v[sh +: 8] = b;
		end
		return v;
	endfunction

	// bytes low first, a short last byte gives its low bits
	function automatic void pack_bits(input logic [DATA_W-1:0] data, input int unsigned n);
		int unsigned left;
		int unsigned take;
		logic [7:0]  byte_v;
		if (!cfg_wen) begin
			err_img = 1'b1;
			return;
		end
		left = n;
		for (int p = 0; p < 8 && left != 0; p++) begin
			byte_v = data[p*8 +: 8];
			take = (left < 8) ? left : 8;
			for (int unsigned i = 0; i < take; i++)
				shift_in_bit(byte_v[take - 1 - i]);
			left -= take;
		end
	endfunction

	function automatic void unwind_to(input int unsigned target);
		if (!cfg_wen) begin
			err_img = 1'b1;
			return;
		end
		while (cur_ofs > target)
			shift_out_bit();
	endfunction

	// expected result of one request, updates the shadow state
	function automatic out_item_t stream_apply(input in_item_t req);
		out_item_t         res;
		logic [DATA_W-1:0] rv;
		int unsigned       cnt;
		int unsigned       idx;
		int unsigned       sh;
		int unsigned       sz;
		rv = '0;
		cnt = req.bit_count;
		if (cnt > MAX_BITS)
			cnt = MAX_BITS;
		case (req.cmd)
			CMD_PUSH: pack_bits(req.data_value, cnt);
			CMD_GET: rv = fetch_bits(cnt);
			CMD_GET_AT: begin
				cur_ofs = req.position;
				rv = fetch_bits(cnt);
			end
			CMD_DROP: unwind_to((cnt > cur_ofs) ? 0 : cur_ofs - cnt);
			CMD_DROP_TO: unwind_to(req.position);
			CMD_MARK: begin
				if (mark_cnt >= MARK_DEPTH) begin
					err_img = 1'b1;
				end else begin
					mark_img[mark_cnt] = cur_ofs;
					mark_cnt++;
				end
			end
			CMD_DROP_RECALL, CMD_POS_RECALL, CMD_IGNORE_RECALL: begin
				if (mark_cnt == 0) begin
					err_img = 1'b1;
				end else begin
					mark_cnt--;
					if (req.cmd == CMD_DROP_RECALL)
						unwind_to(mark_img[mark_cnt]);
					else if (req.cmd == CMD_POS_RECALL)
						cur_ofs = mark_img[mark_cnt];
				end
			end
			CMD_SEEK: cur_ofs = req.position;
			CMD_FINALIZE, CMD_DEFINALIZE: begin
				if (!cfg_wen) begin
					if (req.cmd == CMD_FINALIZE)
						err_img = 1'b1;
				end else if (cur_ofs % 8 != 0 && cur_ofs / 8 < BUF_BYTES) begin
					idx = cur_ofs / 8;
					sh = 8 - cur_ofs % 8;
					if (req.cmd == CMD_FINALIZE)
						buf_img[idx] = buf_img[idx] << sh;
					else
						buf_img[idx] = buf_img[idx] >> sh;
				end
			end
			CMD_CLEAR: begin
				cur_ofs = 0;
				err_img = 1'b0;
			end
			default: ;
		endcase
		sz = (cur_ofs + 7) / 8;
		if (sz > SIZE_MAX)
			sz = SIZE_MAX;
		res.read_value = rv;
		res.bit_offset = OFS_W'(cur_ofs);
		res.size_bytes = SIZE_W'(sz);
		res.error_flag = err_img;
		res.marks_held = MARKS_W'(mark_cnt);
		return res;
	endfunction

	// mostly inside the buffer, now and then anywhere in the field
	function automatic int unsigned pick_position();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(0, OFS_TOP);
		return $urandom_range(0, bit_limit() + 8);
	endfunction

	// one request, valid held across back-to-back requests
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data,
			input int unsigned cnt, input int unsigned pos);
		in_item_t req;
		int       gap;
		req.cmd = cmd;
		req.data_value = data;
		req.bit_count = CNT_W'(cnt);
		req.position = OFS_W'(pos);
		if (sent_count % 64 == 0)
			in_gaps_on = $urandom_range(0, 2) != 0;
		sent_count++;
		gap = in_gaps_on ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pending_results.push_back(stream_apply(req));
		in_data <= req;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int unsigned value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_BUFFER_BYTES)
			cfg_bytes = value & 32'h3FF;
		else
			cfg_wen = (value & 1) != 0;
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("result with no request outstanding at %0t: %h", $time, got);
			return;
		end
		want = pending_results.pop_front();
		if (got.read_value !== want.read_value || got.bit_offset !== want.bit_offset ||
				got.size_bytes !== want.size_bytes || got.error_flag !== want.error_flag ||
				got.marks_held !== want.marks_held) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("mismatch at %0t (expected/actual):", $time);
				$display("  read_value %h / %h", want.read_value, got.read_value);
				$display("  bit_offset %0d / %0d  size_bytes %0d / %0d", want.bit_offset,
					got.bit_offset, want.size_bytes, got.size_bytes);
				$display("  error_flag %b / %b  marks_held %0d / %0d", want.error_flag,
					got.error_flag, want.marks_held, got.marks_held);
			end
		end
	endtask

	// result side: random stall before each result
	initial begin : result_sink
		int hold;
		int seen;
		seen = 0;
		forever begin
			if (seen % 64 == 0)
				out_gaps_on = $urandom_range(0, 2) != 0;
			hold = out_gaps_on ? $urandom_range(0, 15) : 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
			check_result(out_data);
			seen++;
		end
	end

	task automatic test_recall_underflow();
		send_request(CMD_IGNORE_RECALL, '0, 0, 0);
	endtask

	// write every byte once so no read ever sees unwritten storage
	task automatic test_fill();
		for (int i = 0; i < BUF_BYTES / 8; i++)
			send_request(CMD_PUSH, {$urandom, $urandom}, MAX_BITS, 0);
		// the buffer is full, these bits fall at the limit
		send_request(CMD_PUSH, '1, 8, 0);
	endtask

	task automatic test_get_edges();
		send_request(CMD_CLEAR, '0, 0, 0);
		// count above the maximum
		send_request(CMD_GET, '0, 127, 0);
		send_request(CMD_GET, '0, 0, 0);
		// straddles the end of the buffer
		send_request(CMD_GET_AT, '0, 7, BUF_BYTES * 8 - 3);
		// offset saturates at the top
		send_request(CMD_SEEK, '0, 0, OFS_TOP);
		send_request(CMD_GET, '0, 1, 0);
	endtask

	task automatic test_drop_edges();
		// starts beyond the buffer, only the offset moves there
		send_request(CMD_DROP_TO, '0, 0, BUF_BYTES * 8 - 6);
		send_request(CMD_SEEK, '0, 0, 13);
		send_request(CMD_PUSH, 64'h15, 5, 0);
		send_request(CMD_FINALIZE, '0, 0, 0);
		send_request(CMD_DEFINALIZE, '0, 0, 0);
		// count clamps to the offset
		send_request(CMD_DROP, '0, 127, 0);
	endtask

	task automatic test_mark_stack();
		send_request(CMD_SEEK, '0, 0, 100);
		// one mark more than the stack holds
		for (int i = 0; i <= MARK_DEPTH; i++)
			send_request(CMD_MARK, '0, 0, 0);
		send_request(CMD_SEEK, '0, 0, 130);
		send_request(CMD_DROP_RECALL, '0, 0, 0);
		send_request(CMD_POS_RECALL, '0, 0, 0);
		send_request(CMD_IGNORE_RECALL, '0, 0, 0);
	endtask

	task automatic test_read_only();
		write_reg(REG_WRITE_ENABLED, 0);
		send_request(CMD_PUSH, '1, MAX_BITS, 0);
		send_request(CMD_DROP, '0, 10, 0);
		send_request(CMD_DROP_TO, '0, 0, 0);
		send_request(CMD_DROP_RECALL, '0, 0, 0);
		send_request(CMD_FINALIZE, '0, 0, 0);
		send_request(CMD_DEFINALIZE, '0, 0, 0);
		write_reg(REG_WRITE_ENABLED, 1);
	endtask

	// random commands over several register settings
	task automatic test_random_traffic();
		int unsigned      pick;
		int unsigned      cnt;
		int unsigned      pos;
		int unsigned      delta;
		int unsigned      bytes;
		logic [CMD_W-1:0] cmd;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: bytes = BUF_BYTES;
				1: bytes = 1023;
				2: bytes = 0;
				3: bytes = 1;
				default: bytes = $urandom_range(0, 1023);
			endcase
			write_reg(REG_BUFFER_BYTES, bytes);
			write_reg(REG_WRITE_ENABLED, (phase == 3 || phase == 6) ? 0 : 1);
			for (int n = 0; n < 140; n++) begin
				pick = $urandom_range(0, 99);
				if ($urandom_range(0, 15) == 0)
					cnt = $urandom_range(65, 127);
				else
					cnt = $urandom_range(0, 64);
				pos = pick_position();
				if (pick < 22) begin
					cmd = CMD_PUSH;
				end else if (pick < 36) begin
					cmd = CMD_GET;
				end else if (pick < 44) begin
					cmd = CMD_GET_AT;
				end else if (pick < 54) begin
					cmd = CMD_DROP;
				end else if (pick < 60) begin
					cmd = CMD_DROP_TO;
					// mostly a short step back from where we are
					if ($urandom_range(0, 3) != 0) begin
						delta = $urandom_range(0, 100);
						pos = (cur_ofs > delta) ? cur_ofs - delta : 0;
					end
				end else if (pick < 67) begin
					cmd = CMD_MARK;
				end else if (pick < 72) begin
					cmd = CMD_DROP_RECALL;
				end else if (pick < 76) begin
					cmd = CMD_POS_RECALL;
				end else if (pick < 80) begin
					cmd = CMD_IGNORE_RECALL;
				end else if (pick < 87) begin
					cmd = CMD_SEEK;
				end else if (pick < 92) begin
					cmd = CMD_FINALIZE;
				end else if (pick < 96) begin
					cmd = CMD_DEFINALIZE;
				end else if (pick < 98) begin
					cmd = CMD_CLEAR;
				end else begin
					// codes past the last command
					cmd = CMD_W'($urandom_range(13, 15));
				end
				send_request(cmd, {$urandom, $urandom}, cnt, pos);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= 1'b0;
		cfg_data <= '0;
		for (int i = 0; i < BUF_BYTES; i++)
			buf_img[i] = '0;
		for (int i = 0; i < MARK_DEPTH; i++)
			mark_img[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_recall_underflow();
		test_fill();
		test_get_edges();
		test_drop_edges();
		test_mark_stack();
		test_read_only();
		test_random_traffic();

		wait_idle();
		repeat (100) @(posedge clk);
		if (pending_results.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/bspu_pkg.sv
design/bspu_ram.sv
design/bspu_seq.sv
design/bit_stream_packer_unpacker.sv
dv/bit_stream_packer_unpacker_test.sv
